FILE: sv/ocr_pkg.sv
`timescale 1ns / 1ps

package ocr_pkg;

    localparam int BYTE_W = 8;
    localparam int COL_W  = 7;
    localparam int PAGE_W = 3;

    // Item modes
    typedef enum logic [1:0] {
        MODE_CMD  = 2'd0,
        MODE_DATA = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_UNKNOWN  = 2'd1,
        STATUS_BAD_MODE = 2'd2
    } status_t;

    // Memory addressing modes
    typedef enum logic [1:0] {
        ADDR_HORIZ = 2'd0,
        ADDR_VERT  = 2'd1,
        ADDR_PAGE  = 2'd2
    } addr_mode_t;

    localparam logic [1:0] ADDR_CODE_INVALID = 2'd3;

    // Command opcodes
    localparam logic [7:0] OP_CONTRAST      = 8'h81;
    localparam logic [7:0] OP_ENTIRE_OFF    = 8'hA4;
    localparam logic [7:0] OP_ENTIRE_ON     = 8'hA5;
    localparam logic [7:0] OP_NORMAL        = 8'hA6;
    localparam logic [7:0] OP_INVERSE       = 8'hA7;
    localparam logic [7:0] OP_SLEEP         = 8'hAE;
    localparam logic [7:0] OP_WAKE          = 8'hAF;
    localparam logic [7:0] OP_ADDR_MODE     = 8'h20;
    localparam logic [7:0] OP_COL_WINDOW    = 8'h21;
    localparam logic [7:0] OP_PAGE_WINDOW   = 8'h22;
    localparam logic [7:0] OP_SCROLL_R      = 8'h26;
    localparam logic [7:0] OP_SCROLL_L      = 8'h27;
    localparam logic [7:0] OP_SCROLL_VR     = 8'h29;
    localparam logic [7:0] OP_SCROLL_VL     = 8'h2A;
    localparam logic [7:0] OP_SCROLL_OFF    = 8'h2E;
    localparam logic [7:0] OP_SCROLL_ON     = 8'h2F;
    localparam logic [7:0] OP_VSCROLL_AREA  = 8'hA3;
    localparam logic [7:0] OP_SEG_REMAP0    = 8'hA0;
    localparam logic [7:0] OP_SEG_REMAP1    = 8'hA1;
    localparam logic [7:0] OP_MUX_RATIO     = 8'hA8;
    localparam logic [7:0] OP_COM_NORMAL    = 8'hC0;
    localparam logic [7:0] OP_COM_REMAP     = 8'hC8;
    localparam logic [7:0] OP_DISP_OFFSET   = 8'hD3;
    localparam logic [7:0] OP_CLK_DIV       = 8'hD5;
    localparam logic [7:0] OP_PRECHARGE     = 8'hD9;
    localparam logic [7:0] OP_COM_PINS      = 8'hDA;
    localparam logic [7:0] OP_VCOMH         = 8'hDB;
    localparam logic [7:0] OP_NOP           = 8'hE3;
    localparam logic [7:0] OP_COL_LO_FIRST  = 8'h00;
    localparam logic [7:0] OP_COL_LO_LAST   = 8'h0F;
    localparam logic [7:0] OP_COL_HI_FIRST  = 8'h10;
    localparam logic [7:0] OP_COL_HI_LAST   = 8'h1F;
    localparam logic [7:0] OP_LINE_FIRST    = 8'h40;
    localparam logic [7:0] OP_LINE_LAST     = 8'h7F;
    localparam logic [7:0] OP_PAGE_FIRST    = 8'hB0;
    localparam logic [7:0] OP_PAGE_LAST     = 8'hB7;

    // Display RAM write request
    typedef struct packed {
        logic                en;
        logic [COL_W-1:0]    column;
        logic [PAGE_W-1:0]   page;
        logic [BYTE_W-1:0]   data;
    } ram_wr_t;

    // Per-item result of the controller, plus display flags for reads
    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   contrast;
        logic                sleep;
        logic                force_on;
        logic                invert;
    } ctrl_res_t;

endpackage

FILE: sv/oled_controller_command_and_ram_write.sv
// Monochrome OLED controller: command decoder plus a COLUMNS x PAGES byte
// display RAM. Each input transfer carries one byte: mode 0 feeds the command
// decoder (opcode followed by its parameter bytes), mode 1 writes a data byte
// at the current column/page and advances the address by the page,
// horizontal or vertical rule, mode 2 reads one displayed byte at
// read_column/read_page after sleep, entire-display-on and inversion. Every
// input transfer yields exactly one result transfer carrying read_data,
// contrast_level and status, in order. One item is taken per clock while
// in_ready is high: the decoder and address update finish in the cycle of
// the input transfer, and the display RAM does one access per item (write
// for data, read for a display read), with the registered read data forming
// the result in the following cycle. A result waiting on out_ready still lets
// the next item in whenever out_ready is high, so the block takes one item
// per cycle while out_ready stays high. After reset the RAM is swept to
// zero, one entry per cycle, through all COLUMNS*PAGES entries (1024 at
// the defaults); in_ready stays low during that sweep.
`timescale 1ns / 1ps

module oled_controller_command_and_ram_write #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [ocr_pkg::BYTE_W-1:0]    byte_in,
    input  logic [ocr_pkg::COL_W-1:0]     read_column,
    input  logic [ocr_pkg::PAGE_W-1:0]    read_page,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ocr_pkg::BYTE_W-1:0]    read_data,
    output logic [ocr_pkg::BYTE_W-1:0]    contrast_level,
    output logic [1:0]                    status
);

    logic                       accept;
    logic                       clearing;
    logic                       read_ok;
    logic                       rd_en;
    logic [ocr_pkg::BYTE_W-1:0] ram_q;
    ocr_pkg::ram_wr_t           wr;
    ocr_pkg::ctrl_res_t         res;
    ocr_pkg::ctrl_res_t         res_reg;
    logic                       read_hit_reg;
    logic                       out_valid_reg, out_valid_next;

    // take a new item when the RAM sweep is over and the result slot is empty or being drained
    assign in_ready = !clearing && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // a read outside the display returns zero and skips the RAM
    assign read_ok = (mode == ocr_pkg::MODE_READ)
                  && ({1'b0, read_column} < (ocr_pkg::COL_W + 1)'(COLUMNS))
                  && ({1'b0, read_page} < (ocr_pkg::PAGE_W + 1)'(PAGES));
    assign rd_en   = accept && read_ok;

    ocr_ctrl #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .mode    (mode),
        .byte_in (byte_in),
        .wr      (wr),
        .res     (res)
    );

    ocr_ram #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd_en     (rd_en),
        .rd_column (read_column),
        .rd_page   (read_page),
        .rd_data   (ram_q),
        .clearing  (clearing)
    );

    // result slot: set on an input transfer, drop on an output transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // hold the item's result fields until the next input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg      <= res;
            read_hit_reg <= read_ok;
        end
    end

    // display view of the stored byte: sleep blanks, force-on lights, invert flips
    always_comb
    begin
        read_data = '0;
        if (read_hit_reg)
        begin
            if (res_reg.sleep)
                read_data = '0;
            else if (res_reg.force_on)
                read_data = '1;
            else if (res_reg.invert)
                read_data = ~ram_q;
            else
                read_data = ram_q;
        end
    end

    assign out_valid      = out_valid_reg;
    assign contrast_level = res_reg.contrast;
    assign status         = res_reg.status;

    // every input transfer leaves a result in the slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("input transfer did not produce a result");

    // non-read items and reads outside the display show zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !read_hit_reg) |-> (read_data == '0))
        else $error("read_data nonzero on a non-read result");

    // the RAM sweep runs once after reset and never restarts
    assert property (@(posedge clk) disable iff (!rst_n)
        !clearing |=> !clearing)
        else $error("RAM clearing restarted");

    // no RAM write is issued while the sweep owns the RAM
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !wr.en)
        else $error("data write during RAM clearing");

endmodule

FILE: sv/ocr_ctrl.sv
`timescale 1ns / 1ps

module ocr_ctrl #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [1:0]                        mode,
    input  logic [ocr_pkg::BYTE_W-1:0]        byte_in,
    output ocr_pkg::ram_wr_t                  wr,
    output ocr_pkg::ctrl_res_t                res
);

    localparam logic [ocr_pkg::COL_W-1:0]  COL_MAX  = ocr_pkg::COL_W'(COLUMNS - 1);
    localparam logic [ocr_pkg::PAGE_W-1:0] PAGE_MAX = ocr_pkg::PAGE_W'(PAGES - 1);

    logic [ocr_pkg::COL_W-1:0]  cur_column_reg, cur_column_next;
    logic [ocr_pkg::PAGE_W-1:0] cur_page_reg, cur_page_next;
    logic [ocr_pkg::COL_W-1:0]  wcs_reg, wcs_next;
    logic [ocr_pkg::COL_W-1:0]  wce_reg, wce_next;
    logic [ocr_pkg::PAGE_W-1:0] wps_reg, wps_next;
    logic [ocr_pkg::PAGE_W-1:0] wpe_reg, wpe_next;
    logic [ocr_pkg::COL_W-1:0]  pmcs_reg, pmcs_next;
    ocr_pkg::addr_mode_t        addr_mode_reg, addr_mode_next;
    logic [7:0]                 contrast_reg, contrast_next;
    logic                       sleep_reg, sleep_next;
    logic                       force_on_reg, force_on_next;
    logic                       invert_reg, invert_next;
    logic                       pending_valid_reg, pending_valid_next;
    logic [7:0]                 pending_opcode_reg, pending_opcode_next;
    logic [2:0]                 param_count_reg, param_count_next;
    logic [7:0]                 first_param_reg, first_param_next;

    ocr_pkg::status_t           status_next;
    logic                       run_en;
    logic [7:0]                 run_op;
    logic [7:0]                 run_p1;
    logic [7:0]                 run_plast;
    logic [2:0]                 cnt;
    logic [ocr_pkg::COL_W:0]    col_inc;
    logic [ocr_pkg::PAGE_W:0]   page_inc;
    logic                       in_range;

    function automatic logic [2:0] extra_bytes(input logic [7:0] op);
        case (op) inside
            ocr_pkg::OP_SCROLL_R, ocr_pkg::OP_SCROLL_L:      extra_bytes = 3'd6;
            ocr_pkg::OP_SCROLL_VR, ocr_pkg::OP_SCROLL_VL:    extra_bytes = 3'd5;
            ocr_pkg::OP_VSCROLL_AREA, ocr_pkg::OP_COL_WINDOW,
            ocr_pkg::OP_PAGE_WINDOW:                         extra_bytes = 3'd2;
            ocr_pkg::OP_CONTRAST, ocr_pkg::OP_ADDR_MODE, ocr_pkg::OP_MUX_RATIO,
            ocr_pkg::OP_DISP_OFFSET, ocr_pkg::OP_CLK_DIV, ocr_pkg::OP_PRECHARGE,
            ocr_pkg::OP_COM_PINS, ocr_pkg::OP_VCOMH:         extra_bytes = 3'd1;
            default:                                         extra_bytes = 3'd0;
        endcase
    endfunction

    function automatic logic [ocr_pkg::COL_W-1:0] sat_col(input logic [ocr_pkg::COL_W-1:0] c);
        sat_col = (c > COL_MAX) ? COL_MAX : c;
    endfunction

    function automatic logic [ocr_pkg::PAGE_W-1:0] sat_page(
        input logic [ocr_pkg::PAGE_W-1:0] p
    );
        sat_page = (p > PAGE_MAX) ? PAGE_MAX : p;
    endfunction

    assign col_inc  = {1'b0, cur_column_reg} + 1'b1;
    assign page_inc = {1'b0, cur_page_reg} + 1'b1;
    assign in_range = ({1'b0, cur_column_reg} < (ocr_pkg::COL_W + 1)'(COLUMNS))
                   && ({1'b0, cur_page_reg} < (ocr_pkg::PAGE_W + 1)'(PAGES));

    always_comb
    begin
        cur_column_next     = cur_column_reg;
        cur_page_next       = cur_page_reg;
        wcs_next            = wcs_reg;
        wce_next            = wce_reg;
        wps_next            = wps_reg;
        wpe_next            = wpe_reg;
        pmcs_next           = pmcs_reg;
        addr_mode_next      = addr_mode_reg;
        contrast_next       = contrast_reg;
        sleep_next          = sleep_reg;
        force_on_next       = force_on_reg;
        invert_next         = invert_reg;
        pending_valid_next  = pending_valid_reg;
        pending_opcode_next = pending_opcode_reg;
        param_count_next    = param_count_reg;
        first_param_next    = first_param_reg;
        status_next         = ocr_pkg::STATUS_OK;
        run_en              = 1'b0;
        run_op              = byte_in;
        run_p1              = '0;
        run_plast           = '0;
        cnt                 = param_count_reg + 1'b1;

        if (accept)
        begin
            case (mode)
                ocr_pkg::MODE_CMD:
                begin
                    if (!pending_valid_reg)
                    begin
                        pending_opcode_next = byte_in;
                        param_count_next    = '0;
                        if (extra_bytes(byte_in) == 3'd0)
                        begin
                            run_en = 1'b1;
                        end
                        else
                        begin
                            pending_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        param_count_next = cnt;
                        if (cnt == 3'd1)
                        begin
                            first_param_next = byte_in;
                        end
                        if (cnt >= extra_bytes(pending_opcode_reg))
                        begin
                            run_en             = 1'b1;
                            run_op             = pending_opcode_reg;
                            run_p1             = first_param_reg;
                            run_plast          = byte_in;
                            pending_valid_next = 1'b0;
                            param_count_next   = '0;
                        end
                    end
                end
                ocr_pkg::MODE_DATA:
                begin
                    case (addr_mode_reg)
                        ocr_pkg::ADDR_PAGE:
                        begin
                            if (col_inc > {1'b0, COL_MAX})
                                cur_column_next = sat_col(pmcs_reg);
                            else
                                cur_column_next = col_inc[ocr_pkg::COL_W-1:0];
                        end
                        ocr_pkg::ADDR_HORIZ:
                        begin
                            if (col_inc > {1'b0, wce_reg})
                            begin
                                cur_column_next = wcs_reg;
                                if (page_inc > {1'b0, wpe_reg})
                                    cur_page_next = wps_reg;
                                else
                                    cur_page_next = page_inc[ocr_pkg::PAGE_W-1:0];
                            end
                            else
                            begin
                                cur_column_next = col_inc[ocr_pkg::COL_W-1:0];
                            end
                        end
                        ocr_pkg::ADDR_VERT:
                        begin
                            if (page_inc > {1'b0, wpe_reg})
                            begin
                                cur_page_next = wps_reg;
                                if (col_inc > {1'b0, wce_reg})
                                    cur_column_next = wcs_reg;
                                else
                                    cur_column_next = col_inc[ocr_pkg::COL_W-1:0];
                            end
                            else
                            begin
                                cur_page_next = page_inc[ocr_pkg::PAGE_W-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        // carry out a complete command
        if (run_en)
        begin
            case (run_op) inside
                ocr_pkg::OP_CONTRAST:
                    contrast_next = run_plast;
                ocr_pkg::OP_ENTIRE_OFF, ocr_pkg::OP_ENTIRE_ON:
                    force_on_next = run_op[0];
                ocr_pkg::OP_NORMAL, ocr_pkg::OP_INVERSE:
                    invert_next = run_op[0];
                ocr_pkg::OP_SLEEP, ocr_pkg::OP_WAKE:
                    sleep_next = !run_op[0];
                ocr_pkg::OP_ADDR_MODE:
                begin
                    if (run_plast[1:0] == ocr_pkg::ADDR_CODE_INVALID)
                        status_next = ocr_pkg::STATUS_BAD_MODE;
                    else
                        addr_mode_next = ocr_pkg::addr_mode_t'(run_plast[1:0]);
                end
                ocr_pkg::OP_COL_WINDOW:
                begin
                    wcs_next        = sat_col(run_p1[ocr_pkg::COL_W-1:0]);
                    wce_next        = sat_col(run_plast[ocr_pkg::COL_W-1:0]);
                    cur_column_next = sat_col(run_p1[ocr_pkg::COL_W-1:0]);
                end
                ocr_pkg::OP_PAGE_WINDOW:
                begin
                    wps_next      = sat_page(run_p1[ocr_pkg::PAGE_W-1:0]);
                    wpe_next      = sat_page(run_plast[ocr_pkg::PAGE_W-1:0]);
                    cur_page_next = sat_page(run_p1[ocr_pkg::PAGE_W-1:0]);
                end
                ocr_pkg::OP_SCROLL_R, ocr_pkg::OP_SCROLL_L, ocr_pkg::OP_SCROLL_VR,
                ocr_pkg::OP_SCROLL_VL, ocr_pkg::OP_SCROLL_OFF, ocr_pkg::OP_SCROLL_ON,
                ocr_pkg::OP_VSCROLL_AREA, ocr_pkg::OP_SEG_REMAP0, ocr_pkg::OP_SEG_REMAP1,
                ocr_pkg::OP_MUX_RATIO, ocr_pkg::OP_COM_NORMAL, ocr_pkg::OP_COM_REMAP,
                ocr_pkg::OP_DISP_OFFSET, ocr_pkg::OP_CLK_DIV, ocr_pkg::OP_PRECHARGE,
                ocr_pkg::OP_COM_PINS, ocr_pkg::OP_VCOMH, ocr_pkg::OP_NOP,
                [ocr_pkg::OP_LINE_FIRST:ocr_pkg::OP_LINE_LAST]:
                begin
                end
                [ocr_pkg::OP_COL_LO_FIRST:ocr_pkg::OP_COL_LO_LAST]:
                begin
                    pmcs_next       = {pmcs_reg[6:4], run_op[3:0]};
                    cur_column_next = sat_col(pmcs_next);
                end
                [ocr_pkg::OP_COL_HI_FIRST:ocr_pkg::OP_COL_HI_LAST]:
                begin
                    pmcs_next       = {run_op[2:0], pmcs_reg[3:0]};
                    cur_column_next = sat_col(pmcs_next);
                end
                [ocr_pkg::OP_PAGE_FIRST:ocr_pkg::OP_PAGE_LAST]:
                    cur_page_next = sat_page(run_op[ocr_pkg::PAGE_W-1:0]);
                default:
                    status_next = ocr_pkg::STATUS_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_column_reg     <= '0;
            cur_page_reg       <= '0;
            wcs_reg            <= '0;
            wce_reg            <= COL_MAX;
            wps_reg            <= '0;
            wpe_reg            <= PAGE_MAX;
            pmcs_reg           <= '0;
            addr_mode_reg      <= ocr_pkg::ADDR_PAGE;
            contrast_reg       <= 8'h7F;
            sleep_reg          <= 1'b0;
            force_on_reg       <= 1'b0;
            invert_reg         <= 1'b0;
            pending_valid_reg  <= 1'b0;
            pending_opcode_reg <= '0;
            param_count_reg    <= '0;
            first_param_reg    <= '0;
        end
        else
        begin
            cur_column_reg     <= cur_column_next;
            cur_page_reg       <= cur_page_next;
            wcs_reg            <= wcs_next;
            wce_reg            <= wce_next;
            wps_reg            <= wps_next;
            wpe_reg            <= wpe_next;
            pmcs_reg           <= pmcs_next;
            addr_mode_reg      <= addr_mode_next;
            contrast_reg       <= contrast_next;
            sleep_reg          <= sleep_next;
            force_on_reg       <= force_on_next;
            invert_reg         <= invert_next;
            pending_valid_reg  <= pending_valid_next;
            pending_opcode_reg <= pending_opcode_next;
            param_count_reg    <= param_count_next;
            first_param_reg    <= first_param_next;
        end
    end

    assign wr.en     = accept && (mode == ocr_pkg::MODE_DATA) && in_range;
    assign wr.column = cur_column_reg;
    assign wr.page   = cur_page_reg;
    assign wr.data   = byte_in;

    assign res.status   = status_next;
    assign res.contrast = contrast_next;
    assign res.sleep    = sleep_reg;
    assign res.force_on = force_on_reg;
    assign res.invert   = invert_reg;

endmodule

FILE: sv/ocr_ram.sv
`timescale 1ns / 1ps

module ocr_ram #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ocr_pkg::ram_wr_t                  wr,
    input  logic                              rd_en,
    input  logic [ocr_pkg::COL_W-1:0]         rd_column,
    input  logic [ocr_pkg::PAGE_W-1:0]        rd_page,
    output logic [ocr_pkg::BYTE_W-1:0]        rd_data,
    output logic                              clearing
);

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [ocr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [ocr_pkg::BYTE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]          clr_addr_reg, clr_addr_next;
    logic                       clearing_reg, clearing_next;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;

    function automatic logic [ADDR_W-1:0] to_addr(
        input logic [ocr_pkg::COL_W-1:0]  c,
        input logic [ocr_pkg::PAGE_W-1:0] p
    );
        to_addr = ADDR_W'(p) * ADDR_W'(COLUMNS) + ADDR_W'(c);
    endfunction

    assign wr_addr = clearing_reg ? clr_addr_reg : to_addr(wr.column, wr.page);
    assign rd_addr = to_addr(rd_column, rd_page);

    // sweep zeros through every entry after reset
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
                clearing_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[wr_addr] <= '0;
        else if (wr.en)
            mem[wr_addr] <= wr.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;

    localparam int BYTE_W = ocr_pkg::BYTE_W;
    localparam int COL_W  = ocr_pkg::COL_W;
    localparam int PAGE_W = ocr_pkg::PAGE_W;

    // Mode code outside the package enum: the block must leave all state alone
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Length of the one long receiver hold-off, and the point where it starts
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER  = 400;

    // Keep idling until this few host bytes remain, then run flat out
    localparam int CALM_TAIL = 120;

    localparam int RANDOM_ITEMS = 1000;

    // One host byte as presented on the input channel
    typedef struct packed {
        logic [1:0]        m;
        logic [BYTE_W-1:0] b;
        logic [COL_W-1:0]  c;
        logic [PAGE_W-1:0] p;
    } host_byte_t;

    // One result transfer as the block should present it
    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic [BYTE_W-1:0] contrast;
        logic [1:0]        st;
    } display_result_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic [1:0]          mode           = 2'd0;
    logic [BYTE_W-1:0]   byte_in        = '0;
    logic [COL_W-1:0]    read_column    = '0;
    logic [PAGE_W-1:0]   read_page      = '0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [BYTE_W-1:0]   read_data;
    logic [BYTE_W-1:0]   contrast_level;
    logic [1:0]          status;

    host_byte_t          pending_bytes[$];
    display_result_t     expected_results[$];

    host_byte_t          next_byte;
    int                  n_planned      = 0;
    int                  n_accepted     = 0;
    int                  n_mismatch     = 0;
    logic                in_taken       = 1'b0;
    int                  send_gap       = 0;
    int                  stall_left     = 0;
    int                  hold_left      = 0;
    logic                long_hold_done = 1'b0;

    // Predicted controller state
    logic [BYTE_W-1:0]   disp_mem [COLUMNS*PAGES];
    int                  cur_col;
    int                  cur_page;
    int                  win_col_lo;
    int                  win_col_hi;
    int                  win_page_lo;
    int                  win_page_hi;
    logic [COL_W-1:0]    col_start;
    ocr_pkg::addr_mode_t addr_mode;
    logic [BYTE_W-1:0]   contrast;
    logic                asleep;
    logic                force_on;
    logic                invert;
    logic                cmd_pending;
    logic [BYTE_W-1:0]   pend_op;
    int                  pend_count;
    logic [BYTE_W-1:0]   pend_first;

    oled_controller_command_and_ram_write #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .byte_in        (byte_in),
        .read_column    (read_column),
        .read_page      (read_page),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .contrast_level (contrast_level),
        .status         (status)
    );

    always #1 clk = ~clk;

    // Append to the stimulus and expectation queues
    task automatic queue_host_byte(host_byte_t hb);
        pending_bytes = {pending_bytes, hb};
    endtask

    task automatic queue_expected(display_result_t r);
        expected_results = {expected_results, r};
    endtask

    // ------------------------------------------------------------------
    // Display controller predictor
    // ------------------------------------------------------------------

    // Number of parameter bytes that follow each opcode
    function automatic int param_bytes(logic [7:0] op);
        case (op)
            ocr_pkg::OP_SCROLL_R, ocr_pkg::OP_SCROLL_L:                 return 6;
            ocr_pkg::OP_SCROLL_VR, ocr_pkg::OP_SCROLL_VL:               return 5;
            ocr_pkg::OP_VSCROLL_AREA, ocr_pkg::OP_COL_WINDOW,
            ocr_pkg::OP_PAGE_WINDOW:                                    return 2;
            ocr_pkg::OP_CONTRAST, ocr_pkg::OP_ADDR_MODE, ocr_pkg::OP_MUX_RATIO,
            ocr_pkg::OP_DISP_OFFSET, ocr_pkg::OP_CLK_DIV, ocr_pkg::OP_PRECHARGE,
            ocr_pkg::OP_COM_PINS, ocr_pkg::OP_VCOMH:                    return 1;
            default:                                                    return 0;
        endcase
    endfunction

    function automatic int sat_col(int c);
        return (c > COLUMNS - 1) ? COLUMNS - 1 : c;
    endfunction

    function automatic int sat_page(int p);
        return (p > PAGES - 1) ? PAGES - 1 : p;
    endfunction

    // Carry out a complete command; p1 is its first parameter, plast its last
    function automatic ocr_pkg::status_t execute_command(logic [7:0] op, logic [7:0] p1,
                                                         logic [7:0] plast);
        ocr_pkg::status_t st;
        st = ocr_pkg::STATUS_OK;
        case (op)
            ocr_pkg::OP_CONTRAST:                         contrast = plast;
            ocr_pkg::OP_ENTIRE_OFF, ocr_pkg::OP_ENTIRE_ON: force_on = op[0];
            ocr_pkg::OP_NORMAL, ocr_pkg::OP_INVERSE:       invert = op[0];
            ocr_pkg::OP_SLEEP, ocr_pkg::OP_WAKE:           asleep = !op[0];
            ocr_pkg::OP_ADDR_MODE:
            begin
                if (plast[1:0] == ocr_pkg::ADDR_CODE_INVALID)
                    st = ocr_pkg::STATUS_BAD_MODE;
                else
                    addr_mode = ocr_pkg::addr_mode_t'(plast[1:0]);
            end
            ocr_pkg::OP_COL_WINDOW:
            begin
                win_col_lo = sat_col(int'(p1[6:0]));
                win_col_hi = sat_col(int'(plast[6:0]));
                cur_col    = win_col_lo;
            end
            ocr_pkg::OP_PAGE_WINDOW:
            begin
                win_page_lo = sat_page(int'(p1[2:0]));
                win_page_hi = sat_page(int'(plast[2:0]));
                cur_page    = win_page_lo;
            end
            ocr_pkg::OP_SCROLL_R, ocr_pkg::OP_SCROLL_L, ocr_pkg::OP_SCROLL_VR,
            ocr_pkg::OP_SCROLL_VL, ocr_pkg::OP_SCROLL_OFF, ocr_pkg::OP_SCROLL_ON,
            ocr_pkg::OP_VSCROLL_AREA, ocr_pkg::OP_SEG_REMAP0, ocr_pkg::OP_SEG_REMAP1,
            ocr_pkg::OP_MUX_RATIO, ocr_pkg::OP_COM_NORMAL, ocr_pkg::OP_COM_REMAP,
            ocr_pkg::OP_DISP_OFFSET, ocr_pkg::OP_CLK_DIV, ocr_pkg::OP_PRECHARGE,
            ocr_pkg::OP_COM_PINS, ocr_pkg::OP_VCOMH, ocr_pkg::OP_NOP:
                st = ocr_pkg::STATUS_OK;
            default:
            begin
                if (op <= ocr_pkg::OP_COL_LO_LAST)
                begin
                    col_start = {col_start[6:4], op[3:0]};
                    cur_col   = sat_col(int'(col_start));
                end
                else if (op <= ocr_pkg::OP_COL_HI_LAST)
                begin
                    col_start = {op[2:0], col_start[3:0]};
                    cur_col   = sat_col(int'(col_start));
                end
                else if (op >= ocr_pkg::OP_PAGE_FIRST && op <= ocr_pkg::OP_PAGE_LAST)
                    cur_page = sat_page(int'(op[2:0]));
                else if (!(op >= ocr_pkg::OP_LINE_FIRST && op <= ocr_pkg::OP_LINE_LAST))
                    st = ocr_pkg::STATUS_UNKNOWN;
            end
        endcase
        return st;
    endfunction

    // Move the write address on after a data byte
    task automatic advance_address();
        case (addr_mode)
            ocr_pkg::ADDR_PAGE:
            begin
                cur_col++;
                if (cur_col > COLUMNS - 1)
                    cur_col = sat_col(int'(col_start));
            end
            ocr_pkg::ADDR_HORIZ:
            begin
                cur_col++;
                if (cur_col > win_col_hi)
                begin
                    cur_col = win_col_lo;
                    cur_page++;
                    if (cur_page > win_page_hi)
                        cur_page = win_page_lo;
                end
            end
            ocr_pkg::ADDR_VERT:
            begin
                cur_page++;
                if (cur_page > win_page_hi)
                begin
                    cur_page = win_page_lo;
                    cur_col++;
                    if (cur_col > win_col_hi)
                        cur_col = win_col_lo;
                end
            end
            default:
                cur_col = cur_col;
        endcase
    endtask

    // Apply one accepted host byte and queue the result it must produce
    task automatic predict_transfer(host_byte_t hb);
        display_result_t res;
        res.rd = '0;
        res.st = ocr_pkg::STATUS_OK;
        if (hb.m == ocr_pkg::MODE_CMD)
        begin
            if (!cmd_pending)
            begin
                pend_op    = hb.b;
                pend_count = 0;
                if (param_bytes(hb.b) == 0)
                    res.st = execute_command(hb.b, 8'h00, 8'h00);
                else
                    cmd_pending = 1'b1;
            end
            else
            begin
                pend_count++;
                if (pend_count == 1)
                    pend_first = hb.b;
                if (pend_count >= param_bytes(pend_op))
                begin
                    res.st      = execute_command(pend_op, pend_first, hb.b);
                    cmd_pending = 1'b0;
                    pend_count  = 0;
                end
            end
        end
        else if (hb.m == ocr_pkg::MODE_DATA)
        begin
            if (cur_col < COLUMNS && cur_page < PAGES)
                disp_mem[cur_page * COLUMNS + cur_col] = hb.b;
            advance_address();
        end
        else if (hb.m == ocr_pkg::MODE_READ)
        begin
            if (int'(hb.c) < COLUMNS && int'(hb.p) < PAGES)
            begin
                if (asleep)
                    res.rd = 8'h00;
                else if (force_on)
                    res.rd = 8'hFF;
                else if (invert)
                    res.rd = ~disp_mem[int'(hb.p) * COLUMNS + int'(hb.c)];
                else
                    res.rd = disp_mem[int'(hb.p) * COLUMNS + int'(hb.c)];
            end
        end
        res.contrast = contrast;
        queue_expected(res);
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Queue a command or data byte; the read address lines carry noise
    task automatic send_byte(logic [1:0] m, logic [7:0] b);
        host_byte_t hb;
        hb.m = m;
        hb.b = b;
        hb.c = COL_W'($urandom_range(0, 127));
        hb.p = PAGE_W'($urandom_range(0, 7));
        queue_host_byte(hb);
        if (m != MODE_UNUSED)
            n_planned++;
    endtask

    // Queue a display read; the byte lines carry noise
    task automatic send_read(int c, int p);
        host_byte_t hb;
        hb.m = ocr_pkg::MODE_READ;
        hb.b = BYTE_W'($urandom_range(0, 255));
        hb.c = COL_W'(c);
        hb.p = PAGE_W'(p);
        queue_host_byte(hb);
        n_planned++;
    endtask

    // Bias reads toward the corner where windows and column starts put the writes
    task automatic send_random_read();
        if ($urandom_range(0, 2) != 0)
            send_read($urandom_range(0, 31), $urandom_range(0, 3));
        else
            send_read($urandom_range(0, 127), $urandom_range(0, 7));
    endtask

    function automatic logic [7:0] pick_opcode();
        logic [7:0] op;
        case ($urandom_range(0, 15))
            0:       op = ocr_pkg::OP_CONTRAST;
            1:       op = $urandom_range(0, 1) ? ocr_pkg::OP_ENTIRE_ON : ocr_pkg::OP_ENTIRE_OFF;
            2:       op = $urandom_range(0, 1) ? ocr_pkg::OP_INVERSE : ocr_pkg::OP_NORMAL;
            3:       op = ($urandom_range(0, 3) != 0) ? ocr_pkg::OP_WAKE : ocr_pkg::OP_SLEEP;
            4, 5:    op = ocr_pkg::OP_ADDR_MODE;
            6, 7:    op = ocr_pkg::OP_COL_WINDOW;
            8:       op = ocr_pkg::OP_PAGE_WINDOW;
            9:       op = ocr_pkg::OP_COL_LO_FIRST + 8'($urandom_range(0, 15));
            10:      op = ocr_pkg::OP_COL_HI_FIRST +
                          8'(($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 15));
            11:      op = ocr_pkg::OP_PAGE_FIRST + 8'($urandom_range(0, 7));
            12:      op = ocr_pkg::OP_LINE_FIRST + 8'($urandom_range(0, 63));
            13:
            begin
                case ($urandom_range(0, 17))
                    0:       op = ocr_pkg::OP_SCROLL_R;
                    1:       op = ocr_pkg::OP_SCROLL_L;
                    2:       op = ocr_pkg::OP_SCROLL_VR;
                    3:       op = ocr_pkg::OP_SCROLL_VL;
                    4:       op = ocr_pkg::OP_SCROLL_OFF;
                    5:       op = ocr_pkg::OP_SCROLL_ON;
                    6:       op = ocr_pkg::OP_VSCROLL_AREA;
                    7:       op = ocr_pkg::OP_SEG_REMAP0;
                    8:       op = ocr_pkg::OP_SEG_REMAP1;
                    9:       op = ocr_pkg::OP_MUX_RATIO;
                    10:      op = ocr_pkg::OP_COM_NORMAL;
                    11:      op = ocr_pkg::OP_COM_REMAP;
                    12:      op = ocr_pkg::OP_DISP_OFFSET;
                    13:      op = ocr_pkg::OP_CLK_DIV;
                    14:      op = ocr_pkg::OP_PRECHARGE;
                    15:      op = ocr_pkg::OP_COM_PINS;
                    16:      op = ocr_pkg::OP_VCOMH;
                    default: op = ocr_pkg::OP_NOP;
                endcase
            end
            default: op = 8'($urandom_range(0, 255));
        endcase
        return op;
    endfunction

    // Queue one command with its parameters; now and then slip data or reads
    // between the parameters, or cut the parameter list short
    task automatic queue_random_command();
        logic [7:0] op;
        logic [7:0] prm;
        int         n;
        int         lo;
        int         hi;
        op = pick_opcode();
        n  = param_bytes(op);
        if (n > 0 && $urandom_range(0, 19) == 0)
            n = $urandom_range(0, n - 1);
        if (op == ocr_pkg::OP_COL_WINDOW)
        begin
            lo = $urandom_range(0, 15);
            hi = lo + $urandom_range(0, 20);
        end
        else
        begin
            lo = $urandom_range(0, 3);
            hi = lo + $urandom_range(0, 4);
        end
        send_byte(ocr_pkg::MODE_CMD, op);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                if ($urandom_range(0, 1) != 0)
                    send_byte(ocr_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
                else
                    send_random_read();
            end
            prm = 8'($urandom_range(0, 255));
            if ((op == ocr_pkg::OP_COL_WINDOW || op == ocr_pkg::OP_PAGE_WINDOW)
                && $urandom_range(0, 3) != 0)
                prm = 8'((i == 0) ? lo : hi);
            send_byte(ocr_pkg::MODE_CMD, prm);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: present the next host byte once the last one transferred
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                next_byte   = pending_bytes.pop_front();
                mode        <= next_byte.m;
                byte_in     <= next_byte.b;
                read_column <= next_byte.c;
                read_page   <= next_byte.p;
                in_valid    <= 1'b1;
                // Schedule an idle burst after this transfer, except in the tail
                if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 14);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts plus one long hold-off that lets
    // the block fill up and push back on the input side
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && n_accepted >= LONG_HOLD_AFTER)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD_CYCLES - 1;
            out_ready      <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (rst_n && pending_bytes.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 14) - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input transfer, then check each result
    // transfer against the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        n_mismatch++;
    endtask

    always @(posedge clk)
    begin
        display_result_t want;
        in_taken = in_valid && in_ready;
        if (in_taken)
        begin
            predict_transfer({mode, byte_in, read_column, read_page});
            n_accepted++;
        end
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", int'(read_data), 0);
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.rd)
                    report_mismatch("read_data", int'(read_data), int'(want.rd));
                if (contrast_level !== want.contrast)
                    report_mismatch("contrast_level", int'(contrast_level),
                                    int'(want.contrast));
                if (status !== want.st)
                    report_mismatch("status", int'(status), int'(want.st));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset the predictor, build the stimulus, release reset,
    // then wait for the traffic to drain
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < COLUMNS * PAGES; i++)
            disp_mem[i] = '0;
        cur_col     = 0;
        cur_page    = 0;
        win_col_lo  = 0;
        win_col_hi  = COLUMNS - 1;
        win_page_lo = 0;
        win_page_hi = PAGES - 1;
        col_start   = '0;
        addr_mode   = ocr_pkg::ADDR_PAGE;
        contrast    = 8'h7F;
        asleep      = 1'b0;
        force_on    = 1'b0;
        invert      = 1'b0;
        cmd_pending = 1'b0;
        pend_op     = '0;
        pend_count  = 0;
        pend_first  = '0;

        // Directed: far corner of the cleared RAM, page-mode writes, a zero contrast
        // with a data byte slipped into the pending command, each
        // display flag, a bad addressing mode, an unknown opcode, a column
        // window whose end lies below its start, and the unused mode
        send_read(COLUMNS - 1, PAGES - 1);
        send_byte(ocr_pkg::MODE_DATA, 8'hFF);
        send_byte(ocr_pkg::MODE_DATA, 8'hA5);
        send_read(0, 0);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_CONTRAST);
        send_byte(ocr_pkg::MODE_DATA, 8'h3C);
        send_byte(ocr_pkg::MODE_CMD, 8'h00);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_ENTIRE_ON);
        send_read(1, 0);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_ENTIRE_OFF);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_INVERSE);
        send_read(0, 0);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_NORMAL);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_SLEEP);
        send_read(2, 0);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_WAKE);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_ADDR_MODE);
        send_byte(ocr_pkg::MODE_CMD, 8'hFF);
        send_byte(ocr_pkg::MODE_CMD, 8'hFF);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_COL_WINDOW);
        send_byte(ocr_pkg::MODE_CMD, 8'hFF);
        send_byte(ocr_pkg::MODE_CMD, 8'h00);
        send_byte(ocr_pkg::MODE_CMD, ocr_pkg::OP_ADDR_MODE);
        send_byte(ocr_pkg::MODE_CMD, 8'h00);
        send_byte(ocr_pkg::MODE_DATA, 8'h5A);
        send_byte(ocr_pkg::MODE_DATA, 8'h11);
        send_byte(MODE_UNUSED, 8'hFF);

        // Random: mostly well-formed commands and data/read bursts
        while (n_planned < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_random_command();
                4, 5, 6:
                begin
                    repeat ($urandom_range(1, 24))
                        send_byte(ocr_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
                end
                7, 8:
                begin
                    repeat ($urandom_range(1, 8))
                        send_random_read();
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(MODE_UNUSED, 8'($urandom_range(0, 255)));
                    else
                        send_byte(ocr_pkg::MODE_CMD, 8'($urandom_range(0, 255)));
                end
            endcase
        end
        // Close with a readback of the busy corner
        for (int i = 0; i < 16; i++)
            send_read(i, 0);

        // Hold reset, then release it away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain: every byte transferred, every result back, then settle
        while (pending_bytes.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (n_mismatch == 0)
            $display("** oled_controller_command_and_ram_write: PASSED **");
        else
            $display("** oled_controller_command_and_ram_write: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, including the RAM clear
    initial
    begin
        #500_000;
        $display("** oled_controller_command_and_ram_write: FAILED **");
        $finish;
    end

endmodule
